// ===== hdl/chps_pkg.sv =====
// Package with shared constants for the consistent hash peer selector.
`timescale 1ns / 1ps
package chps_pkg;
    localparam int MAX_POINTS_DEF = 4096;
    localparam int MAX_PEERS_DEF  = 32;
    localparam int MAX_TRIES_DEF  = 20;

    localparam logic [2:0] REQ_WR_POINT = 3'd0;
    localparam logic [2:0] REQ_WR_PEER  = 3'd1;
    localparam logic [2:0] REQ_HEALTH   = 3'd2;
    localparam logic [2:0] REQ_START    = 3'd3;
    localparam logic [2:0] REQ_SELECT   = 3'd4;

    localparam logic [1:0] ST_SELECTED = 2'd0;
    localparam logic [1:0] ST_FALLBACK = 2'd1;
    localparam logic [1:0] ST_BUSY     = 2'd2;

    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_PEER_COUNT  = 1'b1;
endpackage

// ===== hdl/chps_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module chps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/consistent_hash_peer_select.sv =====
// Top level of the consistent hash peer selector, one item at a time.
// busy is high while a point write, a peer or health write (read-modify-write),
// or a session start (binary search over the ring) is worked on; a select may be busy
// for the ring position modulo, then a scan of all peers for each ring point tried.
// A result is strobed in the same cycle that busy falls; the receiver cannot stall.
// Reset clears counts, position, tries and tried mask; the tables hold garbage.
`timescale 1ns / 1ps
module consistent_hash_peer_select
    import chps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_PEERS  = MAX_PEERS_DEF,
    parameter int MAX_TRIES  = MAX_TRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [11:0] entry_index,
    input  logic [31:0] hash_value,
    input  logic [4:0]  server_id,
    input  logic [7:0]  weight,
    input  logic [15:0] conn_limit,
    input  logic [7:0]  fail_limit,
    input  logic [15:0] fail_hold,
    input  logic        down_flag,
    input  logic [7:0]  fail_count,
    input  logic [31:0] time_value,
    input  logic [15:0] conn_count,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    output logic        result_valid,
    output logic [4:0]  peer_index,
    output logic [1:0]  status
);
    localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PRW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int NCW = $clog2(MAX_PEERS + 1);
    localparam int TCW = $clog2(MAX_TRIES + 2);
    // peer word: server, weight, eff weight, cur weight, limits, health
    localparam int PW = 5 + 8 + 8 + 16 + 41 + 56;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WRITE  = 4'd1;
    localparam logic [3:0] S_BS_RD  = 4'd2;
    localparam logic [3:0] S_BS_CMP = 4'd3;
    localparam logic [3:0] S_RING   = 4'd4;
    localparam logic [3:0] S_PEER   = 4'd5;
    localparam logic [3:0] S_PEER_W = 4'd6;
    localparam logic [3:0] S_BEST   = 4'd7;
    localparam logic [3:0] S_BEST_W = 4'd8;
    localparam logic [3:0] S_SCAN   = 4'd9;
    localparam logic [3:0] S_MOD    = 4'd10;

    typedef struct packed {
        logic [4:0]  server;
        logic [7:0]  weight;
        logic [7:0]  eff;
        logic [15:0] cur;
        logic [15:0] conn_limit;
        logic [7:0]  fail_limit;
        logic [15:0] fail_hold;
        logic        down;
        logic [7:0]  fails;
        logic [31:0] checked;
        logic [15:0] conns;
    } peer_t;

    logic [3:0]        state_reg, state_next;
    logic [12:0]       point_count_reg;
    logic [5:0]        peer_count_reg;
    logic [12:0]       pos_reg, pos_next;
    logic [TCW-1:0]    tries_reg, tries_next;
    logic [MAX_PEERS-1:0] tried_reg, tried_next;
    logic [PCW-1:0]    lo_reg, lo_next, hi_reg, hi_next;
    logic [PCW-1:0]    rem_reg, rem_next;
    logic [3:0]        mcnt_reg, mcnt_next;
    logic [PRW:0]      pi_reg, pi_next;
    logic [4:0]        srv_reg, srv_next;
    logic              found_reg, found_next;
    logic [PRW-1:0]    best_reg, best_next;
    logic signed [15:0] bestw_reg, bestw_next;
    logic signed [17:0] total_reg, total_next;
    logic              res_v_reg, res_v_next;
    logic [4:0]        res_p_reg, res_p_next;
    logic [1:0]        res_s_reg, res_s_next;
    logic [2:0]        q_req_reg;
    logic [11:0]       q_idx_reg;
    logic [31:0]       q_hash_reg, q_time_reg;
    logic [4:0]        q_srv_reg;
    logic [7:0]        q_w_reg, q_mf_reg, q_fc_reg;
    logic [15:0]       q_mc_reg, q_ft_reg, q_cc_reg;
    logic              q_dn_reg;

    logic [PCW-1:0]    npts;
    logic [NCW-1:0]    npeers;
    logic              accept;

    logic              ring_we;
    logic [PAW-1:0]    ring_raddr;
    logic [36:0]       ring_rdata;
    logic              peer_we;
    logic [PRW-1:0]    peer_waddr, peer_raddr;
    peer_t             peer_wdata, peer_rd;
    logic [PW-1:0]     peer_rdata;

    assign peer_rd = peer_t'(peer_rdata);
    assign npts = (point_count_reg > 13'(MAX_POINTS)) ? PCW'(MAX_POINTS)
                                                      : PCW'(point_count_reg);
    assign npeers = (peer_count_reg > 6'(MAX_PEERS)) ? NCW'(MAX_PEERS)
                                                     : NCW'(peer_count_reg);
    assign busy = (state_reg != S_IDLE);
    assign accept = start && !busy;

    chps_ram #(.WIDTH(37), .DEPTH(MAX_POINTS)) u_ring (
        .clk(clk), .we(ring_we), .waddr(q_idx_reg[PAW-1:0]),
        .wdata({q_hash_reg, q_srv_reg}), .raddr(ring_raddr), .rdata(ring_rdata)
    );

    chps_ram #(.WIDTH(PW), .DEPTH(MAX_PEERS)) u_peer (
        .clk(clk), .we(peer_we), .waddr(peer_waddr),
        .wdata(peer_wdata), .raddr(peer_raddr), .rdata(peer_rdata)
    );

    // Mid point of the binary search.
    logic [PCW:0]    mid_sum;
    logic [PCW-1:0]  mid;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid = mid_sum[PCW:1];

    // Ring position modulo point count: one restoring step per cycle, MSB first,
    // then a wrapping increment for each point that is passed over.
    logic [PCW:0]    rem_shift;
    logic [PCW-1:0]  rem_step;
    logic [PCW-1:0]  rem_inc;
    assign rem_shift = {rem_reg, pos_reg[mcnt_reg]};
    assign rem_step = (rem_shift >= {1'b0, npts}) ? PCW'(rem_shift - {1'b0, npts})
                                                  : rem_shift[PCW-1:0];
    assign rem_inc = ((rem_reg + PCW'(1)) == npts) ? '0 : (rem_reg + PCW'(1));

    // Eligibility of the peer just read.
    logic [PRW-1:0]     pidx;
    logic signed [32:0] since;
    logic               elig;
    logic signed [16:0] cur_sum;
    logic signed [15:0] cur_new;
    assign pidx = pi_reg[PRW-1:0];
    assign since = $signed({1'b0, q_time_reg}) - $signed({1'b0, peer_rd.checked});
    always_comb
    begin
        elig = 1'b1;
        if (tried_reg[pidx]) elig = 1'b0;
        if (peer_rd.down) elig = 1'b0;
        if ((peer_rd.fail_limit != 8'd0) && (peer_rd.fails >= peer_rd.fail_limit) &&
            (since <= $signed({17'd0, peer_rd.fail_hold})))
        begin
            elig = 1'b0;
        end
        if ((peer_rd.conn_limit != 16'd0) && (peer_rd.conns >= peer_rd.conn_limit))
        begin
            elig = 1'b0;
        end
        if (peer_rd.server != srv_reg) elig = 1'b0;
        cur_sum = $signed({peer_rd.cur[15], peer_rd.cur}) + $signed({9'd0, peer_rd.eff});
        if (cur_sum > 17'sd32767) cur_new = 16'sh7fff;
        else cur_new = cur_sum[15:0];
    end

    // Final update of the chosen peer.
    logic signed [18:0] best_diff;
    logic signed [15:0] best_cur;
    always_comb
    begin
        best_diff = $signed({{3{peer_rd.cur[15]}}, peer_rd.cur})
                  - $signed({total_reg[17], total_reg});
        if (best_diff < -19'sd32768) best_cur = 16'sh8000;
        else if (best_diff > 19'sd32767) best_cur = 16'sh7fff;
        else best_cur = best_diff[15:0];
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        tries_next = tries_reg;
        tried_next = tried_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        rem_next = rem_reg;
        mcnt_next = mcnt_reg;
        pi_next = pi_reg;
        srv_next = srv_reg;
        found_next = found_reg;
        best_next = best_reg;
        bestw_next = bestw_reg;
        total_next = total_reg;
        res_v_next = 1'b0;
        res_p_next = res_p_reg;
        res_s_next = res_s_reg;
        ring_we = 1'b0;
        ring_raddr = mid[PAW-1:0];
        peer_we = 1'b0;
        peer_waddr = pidx;
        peer_raddr = pidx;
        peer_wdata = peer_rd;
        case (state_reg)
            S_IDLE:
            begin
                if (accept) state_next = S_WRITE;
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
                case (q_req_reg)
                    REQ_WR_POINT:
                    begin
                        ring_we = (32'(q_idx_reg) < 32'(MAX_POINTS));
                    end
                    REQ_WR_PEER, REQ_HEALTH:
                    begin
                        // Read-modify-write: read now, write in S_BEST_W.
                        peer_raddr = q_idx_reg[PRW-1:0];
                        if (32'(q_idx_reg) < 32'(MAX_PEERS)) state_next = S_BEST_W;
                    end
                    REQ_START:
                    begin
                        lo_next = '0;
                        hi_next = npts;
                        tries_next = '0;
                        tried_next = '0;
                        if (npts == '0) pos_next = '0;
                        else state_next = S_BS_RD;
                    end
                    REQ_SELECT:
                    begin
                        res_p_next = '0;
                        if ((32'(tries_reg) > 32'(MAX_TRIES)) || (npeers == NCW'(1)))
                        begin
                            res_v_next = 1'b1;
                            res_s_next = ST_FALLBACK;
                        end
                        else if (npeers == '0)
                        begin
                            res_v_next = 1'b1;
                            res_s_next = ST_BUSY;
                        end
                        else if (npts == '0)
                        begin
                            res_v_next = 1'b1;
                            res_s_next = ST_FALLBACK;
                        end
                        else
                        begin
                            rem_next = '0;
                            mcnt_next = 4'd12;
                            state_next = S_MOD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MOD:
            begin
                rem_next = rem_step;
                if (mcnt_reg == 4'd0)
                begin
                    ring_raddr = rem_step[PAW-1:0];
                    state_next = S_RING;
                end
                else mcnt_next = mcnt_reg - 4'd1;
            end
            S_BS_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    ring_raddr = mid[PAW-1:0];
                    state_next = S_BS_CMP;
                end
                else
                begin
                    pos_next = 13'(lo_reg);
                    state_next = S_IDLE;
                end
            end
            S_BS_CMP:
            begin
                state_next = S_BS_RD;
                if (q_hash_reg > ring_rdata[36:5]) lo_next = mid + PCW'(1);
                else if (q_hash_reg < ring_rdata[36:5]) hi_next = mid;
                else
                begin
                    pos_next = 13'(mid);
                    state_next = S_IDLE;
                end
            end
            S_RING:
            begin
                srv_next = ring_rdata[4:0];
                pi_next = '0;
                found_next = 1'b0;
                total_next = '0;
                peer_raddr = '0;
                state_next = S_PEER;
            end
            S_PEER:
            begin
                // Peer pi_reg is on the read port; if eligible, update and write it back.
                if (elig)
                begin
                    peer_wdata.cur = cur_new;
                    if (peer_rd.eff < peer_rd.weight) peer_wdata.eff = peer_rd.eff + 8'd1;
                    peer_we = 1'b1;
                    total_next = total_reg + $signed({10'd0, peer_rd.eff});
                    if (!found_reg || (cur_new > bestw_reg))
                    begin
                        found_next = 1'b1;
                        best_next = pidx;
                        bestw_next = cur_new;
                    end
                end
                pi_next = pi_reg + (PRW+1)'(1);
                state_next = S_PEER_W;
            end
            S_PEER_W:
            begin
                // Gap state so the next read sees the write just made.
                peer_raddr = pidx;
                if (32'(pi_reg) >= 32'(npeers))
                begin
                    if (found_reg)
                    begin
                        peer_raddr = best_reg;
                        state_next = S_BEST;
                    end
                    else
                    begin
                        pos_next = pos_reg + 13'd1;
                        rem_next = rem_inc;
                        tries_next = tries_reg + TCW'(1);
                        state_next = S_SCAN;
                    end
                end
                else state_next = S_PEER;
            end
            S_SCAN:
            begin
                if (32'(tries_reg) > 32'(MAX_TRIES))
                begin
                    res_v_next = 1'b1;
                    res_p_next = '0;
                    res_s_next = ST_FALLBACK;
                    state_next = S_IDLE;
                end
                else
                begin
                    ring_raddr = rem_reg[PAW-1:0];
                    state_next = S_RING;
                end
            end
            S_BEST:
            begin
                peer_waddr = best_reg;
                peer_wdata.cur = best_cur;
                if (peer_rd.conns != 16'hffff) peer_wdata.conns = peer_rd.conns + 16'd1;
                if (since > $signed({17'd0, peer_rd.fail_hold}))
                begin
                    peer_wdata.checked = q_time_reg;
                end
                peer_we = 1'b1;
                tried_next[best_reg] = 1'b1;
                res_v_next = 1'b1;
                res_p_next = 5'(best_reg);
                res_s_next = ST_SELECTED;
                state_next = S_IDLE;
            end
            S_BEST_W:
            begin
                peer_waddr = q_idx_reg[PRW-1:0];
                peer_we = 1'b1;
                if (q_req_reg == REQ_WR_PEER)
                begin
                    peer_wdata.server = q_srv_reg;
                    peer_wdata.weight = q_w_reg;
                    peer_wdata.eff = q_w_reg;
                    peer_wdata.cur = '0;
                    peer_wdata.conn_limit = q_mc_reg;
                    peer_wdata.fail_limit = q_mf_reg;
                    peer_wdata.fail_hold = q_ft_reg;
                    peer_wdata.down = q_dn_reg;
                end
                else
                begin
                    peer_wdata.fails = q_fc_reg;
                    peer_wdata.checked = q_time_reg;
                    peer_wdata.conns = q_cc_reg;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            point_count_reg <= '0;
            peer_count_reg <= '0;
            pos_reg <= '0;
            tries_reg <= '0;
            tried_reg <= '0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            tries_reg <= tries_next;
            tried_reg <= tried_next;
            res_v_reg <= res_v_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_POINT_COUNT) point_count_reg <= cfg_data;
                else peer_count_reg <= cfg_data[5:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        rem_reg <= rem_next;
        mcnt_reg <= mcnt_next;
        pi_reg <= pi_next;
        srv_reg <= srv_next;
        found_reg <= found_next;
        best_reg <= best_next;
        bestw_reg <= bestw_next;
        total_reg <= total_next;
        res_p_reg <= res_p_next;
        res_s_reg <= res_s_next;
        if (accept)
        begin
            q_req_reg <= req_type;
            q_idx_reg <= entry_index;
            q_hash_reg <= hash_value;
            q_srv_reg <= server_id;
            q_w_reg <= weight;
            q_mc_reg <= conn_limit;
            q_mf_reg <= fail_limit;
            q_ft_reg <= fail_hold;
            q_dn_reg <= down_flag;
            q_fc_reg <= fail_count;
            q_time_reg <= time_value;
            q_cc_reg <= conn_count;
        end
    end

    assign result_valid = res_v_reg;
    assign peer_index = res_p_reg;
    assign status = res_s_reg;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_v_reg |=> !res_v_reg)
        else $error("two results in a row");
    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_v_reg |-> (state_reg == S_IDLE))
        else $error("result while still working");
    a_sel_peer: assert property (@(posedge clk) disable iff (!rst_n)
        (res_v_reg && res_s_reg == ST_SELECTED) |-> tried_reg[res_p_reg[PRW-1:0]])
        else $error("selected peer not marked tried");
    a_bs_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BS_CMP) |-> (lo_reg < hi_reg))
        else $error("binary search out of range");
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the consistent hash peer selector.
`timescale 1ns / 1ps
module testbench;
    import chps_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST = 3'd7;

    typedef struct {
        logic [2:0]  req;
        logic [11:0] idx;
        logic [31:0] hv;
        logic [4:0]  sid;
        logic [7:0]  wt;
        logic [15:0] mc;
        logic [7:0]  mf;
        logic [15:0] ft;
        logic        dn;
        logic [7:0]  fc;
        logic [31:0] tv;
        logic [15:0] cc;
    } lb_request_t;

    typedef struct {
        logic [4:0] peer;
        logic [1:0] st;
    } pick_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  req_type = '0;
    logic [11:0] entry_index = '0;
    logic [31:0] hash_value = '0;
    logic [4:0]  server_id = '0;
    logic [7:0]  weight = '0;
    logic [15:0] conn_limit = '0;
    logic [7:0]  fail_limit = '0;
    logic [15:0] fail_hold = '0;
    logic        down_flag = 1'b0;
    logic [7:0]  fail_count = '0;
    logic [31:0] time_value = '0;
    logic [15:0] conn_count = '0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [12:0] cfg_data = '0;
    logic        result_valid;
    logic [4:0]  peer_index;
    logic [1:0]  status;

    consistent_hash_peer_select dut (.*);

    // Shadow copy of the balancer state.
    logic [31:0] sh_ring_hash [MAX_POINTS_DEF];
    logic [4:0]  sh_ring_srv [MAX_POINTS_DEF];
    logic [4:0]  sh_peer_srv [MAX_PEERS_DEF];
    logic [7:0]  sh_weight [MAX_PEERS_DEF];
    logic [7:0]  sh_eff [MAX_PEERS_DEF];
    int          sh_cur [MAX_PEERS_DEF];
    logic [15:0] sh_conn_limit [MAX_PEERS_DEF];
    logic [7:0]  sh_fail_limit [MAX_PEERS_DEF];
    logic [15:0] sh_timeout [MAX_PEERS_DEF];
    logic        sh_down [MAX_PEERS_DEF];
    logic [7:0]  sh_fails [MAX_PEERS_DEF];
    logic [31:0] sh_checked [MAX_PEERS_DEF];
    logic [15:0] sh_conns [MAX_PEERS_DEF];
    logic [12:0] sh_points = '0;
    logic [5:0]  sh_peers = '0;
    logic [12:0] sh_pos = '0;
    int          sh_tries = 0;
    logic [31:0] sh_tried = '0;

    lb_request_t request_queue[$];
    pick_t       expected_picks[$];
    lb_request_t cur_req;
    int          idle_pct = 0;
    int          errors = 0;
    int          cycles = 0;
    int          ring_len = 0;
    int          status_seen [3] = '{0, 0, 0};
    logic [31:0] now_time = 32'd1000;

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic int sat16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint elapsed(input logic [31:0] now, input logic [31:0] then_t);
        return longint'(now) - longint'(then_t);
    endfunction

    function automatic int ring_search(input logic [31:0] key, input int n);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (key > sh_ring_hash[mid]) lo = mid + 1;
            else if (key < sh_ring_hash[mid]) hi = mid;
            else return mid;
        end
        return lo;
    endfunction

    function automatic bit peer_usable(input int i, input logic [4:0] srv,
                                       input logic [31:0] now);
        if (sh_tried[i]) return 0;
        if (sh_down[i]) return 0;
        if (sh_fail_limit[i] != 0 && sh_fails[i] >= sh_fail_limit[i] &&
            elapsed(now, sh_checked[i]) <= longint'(sh_timeout[i]))
            return 0;
        if (sh_conn_limit[i] != 0 && sh_conns[i] >= sh_conn_limit[i]) return 0;
        return sh_peer_srv[i] == srv;
    endfunction

    function automatic pick_t pick_peer(input logic [31:0] now);
        pick_t r;
        int np;
        int npts;
        int total;
        int best;
        bit found;
        logic [4:0] srv;
        np = (sh_peers > MAX_PEERS_DEF) ? MAX_PEERS_DEF : int'(sh_peers);
        npts = (sh_points > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(sh_points);
        r.peer = '0;
        r.st = ST_FALLBACK;
        if (sh_tries > MAX_TRIES_DEF || np == 1) return r;
        if (np == 0) begin
            r.st = ST_BUSY;
            return r;
        end
        if (npts == 0) return r;
        while (1) begin
            srv = sh_ring_srv[int'(sh_pos) % npts];
            total = 0;
            best = 0;
            found = 0;
            for (int i = 0; i < np; i++) begin
                if (!peer_usable(i, srv, now)) continue;
                sh_cur[i] = sat16(sh_cur[i] + int'(sh_eff[i]));
                total += int'(sh_eff[i]);
                if (sh_eff[i] < sh_weight[i]) sh_eff[i]++;
                if (!found || sh_cur[i] > sh_cur[best]) begin
                    best = i;
                    found = 1;
                end
            end
            if (found) begin
                sh_cur[best] = sat16(sh_cur[best] - total);
                if (sh_conns[best] != 16'hFFFF) sh_conns[best]++;
                if (elapsed(now, sh_checked[best]) > longint'(sh_timeout[best]))
                    sh_checked[best] = now;
                sh_tried[best] = 1'b1;
                r.peer = best[4:0];
                r.st = ST_SELECTED;
                return r;
            end
            sh_pos = sh_pos + 13'd1;
            sh_tries++;
            if (sh_tries > MAX_TRIES_DEF) return r;
        end
    endfunction

    function automatic void apply_request(input lb_request_t q);
        int n;
        case (q.req)
            REQ_WR_POINT: begin
                sh_ring_hash[q.idx] = q.hv;
                sh_ring_srv[q.idx] = q.sid;
            end
            REQ_WR_PEER: if (q.idx < MAX_PEERS_DEF) begin
                sh_peer_srv[q.idx] = q.sid;
                sh_weight[q.idx] = q.wt;
                sh_eff[q.idx] = q.wt;
                sh_cur[q.idx] = 0;
                sh_conn_limit[q.idx] = q.mc;
                sh_fail_limit[q.idx] = q.mf;
                sh_timeout[q.idx] = q.ft;
                sh_down[q.idx] = q.dn;
            end
            REQ_HEALTH: if (q.idx < MAX_PEERS_DEF) begin
                sh_fails[q.idx] = q.fc;
                sh_checked[q.idx] = q.tv;
                sh_conns[q.idx] = q.cc;
            end
            REQ_START: begin
                n = (sh_points > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(sh_points);
                sh_pos = (n != 0) ? 13'(ring_search(q.hv, n)) : '0;
                sh_tries = 0;
                sh_tried = '0;
            end
            REQ_SELECT: expected_picks.push_back(pick_peer(q.tv));
            default: ;
        endcase
    endfunction

    // Driver: a beat is taken when start is high and busy is low.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) apply_request(cur_req);
            if (!start || !busy) begin
                if (request_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_req = request_queue.pop_front();
                    start <= 1'b1;
                    req_type <= cur_req.req;
                    entry_index <= cur_req.idx;
                    hash_value <= cur_req.hv;
                    server_id <= cur_req.sid;
                    weight <= cur_req.wt;
                    conn_limit <= cur_req.mc;
                    fail_limit <= cur_req.mf;
                    fail_hold <= cur_req.ft;
                    down_flag <= cur_req.dn;
                    fail_count <= cur_req.fc;
                    time_value <= cur_req.tv;
                    conn_count <= cur_req.cc;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is matched against the oldest prediction.
    always @(posedge clk) begin
        pick_t e;
        if (rst_n && result_valid) begin
            if (expected_picks.size() == 0) begin
                mismatch($sformatf("unexpected result peer %0d status %0d",
                                   peer_index, status));
            end else begin
                e = expected_picks.pop_front();
                if (status !== e.st)
                    mismatch($sformatf("status %0d, expected %0d", status, e.st));
                if (peer_index !== e.peer)
                    mismatch($sformatf("peer_index %0d, expected %0d",
                                       peer_index, e.peer));
                if (e.st <= ST_BUSY) status_seen[e.st]++;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench failed");
            $finish;
        end
    end

    function automatic lb_request_t noise_request();
        lb_request_t q;
        q.req = 3'($urandom);
        q.idx = 12'($urandom);
        q.hv = $urandom;
        q.sid = 5'($urandom);
        q.wt = 8'($urandom);
        q.mc = 16'($urandom);
        q.mf = 8'($urandom);
        q.ft = 16'($urandom);
        q.dn = 1'($urandom);
        q.fc = 8'($urandom);
        q.tv = $urandom;
        q.cc = 16'($urandom);
        return q;
    endfunction

    task automatic send_peer(input int i, input bit wild);
        lb_request_t q;
        q = noise_request();
        q.req = REQ_WR_PEER;
        q.idx = 12'(i);
        if (!wild) begin
            q.sid = ($urandom_range(19) == 0) ? 5'd31 : 5'($urandom_range(3));
            q.wt = ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(10));
            q.mc = ($urandom_range(2) == 0) ? 16'($urandom_range(6)) : '0;
            q.mf = 8'($urandom_range(3));
            q.ft = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(60));
            q.dn = ($urandom_range(9) == 0);
        end
        request_queue.push_back(q);
    endtask

    task automatic send_health(input int i, input bit wild);
        lb_request_t q;
        q = noise_request();
        q.req = REQ_HEALTH;
        q.idx = 12'(i);
        if (!wild) begin
            q.fc = 8'($urandom_range(4));
            q.tv = now_time - 32'($urandom_range(100)) + 32'd20;
            q.cc = ($urandom_range(15) == 0) ? 16'hFFFF : 16'($urandom_range(6));
        end
        request_queue.push_back(q);
    endtask

    task automatic send_simple(input logic [2:0] kind, input logic [31:0] key);
        lb_request_t q;
        q = noise_request();
        q.req = kind;
        q.hv = key;
        now_time += 32'($urandom_range(30));
        q.tv = now_time;
        request_queue.push_back(q);
    endtask

    // Sorted, duplicate free ring from 0 up to all ones.
    task automatic load_ring(input int len);
        lb_request_t q;
        longint step;
        step = 64'h1_0000_0000 / len;
        for (int i = 0; i < len; i++) begin
            q = noise_request();
            q.req = REQ_WR_POINT;
            q.idx = 12'(i);
            if (i == 0) q.hv = '0;
            else if (i == len - 1) q.hv = 32'hFFFF_FFFF;
            else q.hv = 32'(i * step + $urandom_range(int'(step) - 1, 1));
            q.sid = ($urandom_range(15) == 0) ? 5'd31 : 5'($urandom_range(3));
            request_queue.push_back(q);
        end
        ring_len = len;
    endtask

    task automatic settle();
        do @(posedge clk);
        while (request_queue.size() != 0 || start || busy || expected_picks.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic which, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= 13'(value);
        if (which == CFG_POINT_COUNT) sh_points = 13'(value);
        else sh_peers = 6'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_counts(input int points, input int peers);
        settle();
        write_reg(CFG_POINT_COUNT, points);
        write_reg(CFG_PEER_COUNT, peers);
    endtask

    task automatic run_phase(input int points, input int peers, input int items,
                             input int pct);
        int sent;
        int n;
        int k;
        logic [31:0] key;
        lb_request_t q;
        set_counts(points, peers);
        idle_pct = pct;
        n = (points > MAX_POINTS_DEF) ? MAX_POINTS_DEF : points;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(9) < 7) begin
                case ($urandom_range(9))
                    0: key = '0;
                    1: key = 32'hFFFF_FFFF;
                    2, 3, 4, 5: key = sh_ring_hash[$urandom_range(n - 1)];
                    default: key = $urandom;
                endcase
                send_simple(REQ_START, key);
                k = $urandom_range(24, 1);
                for (int j = 0; j < k; j++) begin
                    if ($urandom_range(7) == 0) send_health($urandom_range(31), 0);
                    send_simple(REQ_SELECT, '0);
                end
                sent += k + 1;
            end else begin
                case ($urandom_range(5))
                    0: send_peer($urandom_range(31), 0);
                    1: send_peer($urandom_range(4095, 32), 1);
                    2: send_health($urandom_range(31), 1'($urandom_range(1)));
                    3: begin
                        q = noise_request();
                        q.req = 3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
                        request_queue.push_back(q);
                    end
                    4: if (ring_len < MAX_POINTS_DEF) begin
                        q = noise_request();
                        q.req = REQ_WR_POINT;
                        q.idx = 12'($urandom_range(4095, ring_len));
                        request_queue.push_back(q);
                    end
                    default: send_simple(REQ_SELECT, '0);
                endcase
                sent++;
            end
        end
    endtask

    initial begin
        lb_request_t q;
        for (int i = 0; i < MAX_PEERS_DEF; i++) sh_cur[i] = 0;
        wait (rst_n);
        idle_pct = 36;
        // Right after reset there are no peers, so a select must say busy.
        send_simple(REQ_SELECT, '0);
        q = noise_request();
        q.req = REQ_UNUSED_LAST;
        request_queue.push_back(q);
        for (int i = 0; i < MAX_PEERS_DEF; i++) begin
            send_peer(i, 0);
            send_health(i, 0);
        end
        load_ring(64);
        set_counts(16, 1);
        send_simple(REQ_SELECT, '0);
        set_counts(0, 8);
        send_simple(REQ_SELECT, '0);
        set_counts(16, 0);
        send_simple(REQ_SELECT, '0);
        set_counts(16, 8);
        send_simple(REQ_START, '0);
        send_simple(REQ_SELECT, '0);
        send_simple(REQ_SELECT, '0);
        // A key past the last point wraps around to the first one.
        send_simple(REQ_START, 32'hFFFF_FFFF);
        send_simple(REQ_SELECT, '0);
        send_peer(4095, 1);
        send_health(32, 1);
        send_simple(REQ_START, sh_ring_hash[5]);
        for (int j = 0; j < 12; j++) send_simple(REQ_SELECT, '0);

        run_phase(64, 32, 50, 36);
        run_phase(5, 63, 50, 36);
        run_phase(1, 3, 40, 36);
        now_time = 32'hFFFF_FF80;
        run_phase(33, 17, 50, 61);
        run_phase(64, 2, 40, 61);
        settle();
        run_phase(64, 32, 40, 0);
        run_phase(48, 20, 40, 0);
        run_phase(7, 32, 40, 0);
        settle();

        $display("Checked %0d selects, %0d fall backs and %0d busy answers",
                 status_seen[ST_SELECTED], status_seen[ST_FALLBACK], status_seen[ST_BUSY]);
        $display("over rings of 0 to 64 points and 0 to 63 configured peers; %0d mismatches",
                 errors);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
